FILE: rtl/ppt_pkg.sv
package ppt_pkg;

  localparam int unsigned ELEM_W  = 21;
  localparam int unsigned PT_W    = 24;
  localparam int unsigned ROW_W   = 3 * ELEM_W;
  localparam int unsigned PROD_W  = ELEM_W + PT_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned QB      = PT_W + 1;
  localparam int unsigned REM_W   = SUM_W + QB;
  localparam int unsigned IDX_W   = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_ZERO = 2'd0,
    REG_ROW_ONE  = 2'd1,
    REG_ROW_TWO  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic              zero_den;
    logic              neg_x;
    logic              neg_y;
    logic              nz_x;
    logic              nz_y;
    logic              ovf_x;
    logic              ovf_y;
    logic [SUM_W-1:0]  den;
    logic [REM_W-1:0]  rem_x;
    logic [REM_W-1:0]  rem_y;
    logic [QB-1:0]     q_x;
    logic [QB-1:0]     q_y;
  } div_t;

endpackage

FILE: rtl/ppt_point_if.sv
interface ppt_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [ppt_pkg::PT_W-1:0]   point_x;
  logic signed [ppt_pkg::PT_W-1:0]   point_y;
  logic signed [ppt_pkg::PT_W-1:0]   point_w;
  modport source (output valid, point_x, point_y, point_w, input ready);
  modport sink (input valid, point_x, point_y, point_w, output ready);
endinterface

FILE: rtl/ppt_result_if.sv
interface ppt_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [ppt_pkg::PT_W-1:0]   out_x;
  logic signed [ppt_pkg::PT_W-1:0]   out_y;
  logic                              bad_divide;
  modport source (output valid, out_x, out_y, bad_divide, input ready);
  modport sink (input valid, out_x, out_y, bad_divide, output ready);
endinterface

FILE: rtl/ppt_cfg_if.sv
interface ppt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ppt_pkg::IDX_W-1:0]        index;
  logic [ppt_pkg::ROW_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ppt_mac.sv
module ppt_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [ppt_pkg::ROW_W-1:0]           row_i,
  input  logic signed [ppt_pkg::PT_W-1:0]     pt_x_i,
  input  logic signed [ppt_pkg::PT_W-1:0]     pt_y_i,
  input  logic signed [ppt_pkg::PT_W-1:0]     pt_w_i,
  output logic                                valid_o,
  output logic signed [ppt_pkg::SUM_W-1:0]    sum_o
);

  logic signed [ppt_pkg::PROD_W-1:0] p0_q, p1_q, p2_q;
  logic signed [ppt_pkg::ELEM_W-1:0] e0, e1, e2;
  logic                              v_q;
  logic signed [ppt_pkg::SUM_W-1:0]  sum_d, sum_q;
  logic                              vs_q;

  assign e0 = $signed(row_i[0*ppt_pkg::ELEM_W +: ppt_pkg::ELEM_W]);
  assign e1 = $signed(row_i[1*ppt_pkg::ELEM_W +: ppt_pkg::ELEM_W]);
  assign e2 = $signed(row_i[2*ppt_pkg::ELEM_W +: ppt_pkg::ELEM_W]);

  assign sum_d = ppt_pkg::SUM_W'(p0_q) + ppt_pkg::SUM_W'(p1_q) + ppt_pkg::SUM_W'(p2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= e0 * pt_x_i;
      p1_q  <= e1 * pt_y_i;
      p2_q  <= e2 * pt_w_i;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= 1'b0;
      vs_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= valid_i;
      vs_q <= v_q;
    end
  end

  assign valid_o = vs_q;
  assign sum_o   = sum_q;

endmodule

FILE: rtl/ppt_div_cell.sv
module ppt_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ppt_pkg::div_t        data_i,
  output logic                 valid_o,
  output ppt_pkg::div_t        data_o
);

  logic [ppt_pkg::REM_W-1:0] dsh;
  logic                      take_x, take_y;
  ppt_pkg::div_t             d_d, d_q;
  logic                      v_q;

  assign dsh    = ppt_pkg::REM_W'(data_i.den) << BIT;
  assign take_x = data_i.rem_x >= dsh;
  assign take_y = data_i.rem_y >= dsh;

  always_comb begin
    d_d       = data_i;
    d_d.rem_x = take_x ? data_i.rem_x - dsh : data_i.rem_x;
    d_d.rem_y = take_y ? data_i.rem_y - dsh : data_i.rem_y;
    d_d.q_x   = {data_i.q_x[ppt_pkg::QB-2:0], take_x};
    d_d.q_y   = {data_i.q_y[ppt_pkg::QB-2:0], take_y};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

FILE: rtl/projective_point_transform_top.sv
// registers from an accepted point to its result: products, sums,
// divider set-up, 25 restoring divider cells, output register
// throughput: one point per cycle; the whole pipeline holds while a result waits
// reset: matrix rows return to their reset values, all pipeline valid bits clear
module projective_point_transform_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ppt_point_if.sink     point_i,
  ppt_result_if.source  result_o,
  ppt_cfg_if.sink       cfg_i
);

  localparam int unsigned SW = ppt_pkg::SUM_W;
  localparam int unsigned RW = ppt_pkg::REM_W;
  localparam int unsigned QB = ppt_pkg::QB;

  logic [ppt_pkg::ROW_W-1:0] row0_q, row1_q, row2_q;
  logic                      en;
  logic                      vx, vy, vw;
  logic signed [SW-1:0]      tx, ty, tw;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= ppt_pkg::ROW_W'(64'd4398046576640);
      row1_q <= ppt_pkg::ROW_W'(64'd137438953472);
      row2_q <= ppt_pkg::ROW_W'(64'd65536);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ppt_pkg::REG_ROW_ZERO: row0_q <= cfg_i.data;
        ppt_pkg::REG_ROW_ONE:  row1_q <= cfg_i.data;
        ppt_pkg::REG_ROW_TWO:  row2_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign en            = !result_o.valid || result_o.ready;
  assign point_i.ready = en;

  ppt_mac u_mac_x (.clk_i, .rst_ni, .en_i(en), .valid_i(point_i.valid), .row_i(row0_q),
    .pt_x_i(point_i.point_x), .pt_y_i(point_i.point_y), .pt_w_i(point_i.point_w),
    .valid_o(vx), .sum_o(tx));
  ppt_mac u_mac_y (.clk_i, .rst_ni, .en_i(en), .valid_i(point_i.valid), .row_i(row1_q),
    .pt_x_i(point_i.point_x), .pt_y_i(point_i.point_y), .pt_w_i(point_i.point_w),
    .valid_o(vy), .sum_o(ty));
  ppt_mac u_mac_w (.clk_i, .rst_ni, .en_i(en), .valid_i(point_i.valid), .row_i(row2_q),
    .pt_x_i(point_i.point_x), .pt_y_i(point_i.point_y), .pt_w_i(point_i.point_w),
    .valid_o(vw), .sum_o(tw));

  // divider set-up: magnitudes, signs, early overflow
  logic [SW-1:0]  nx, ny, dm;
  logic [RW-1:0]  dtop;
  ppt_pkg::div_t  prep_d, prep_q;
  logic           prep_v_q;

  assign nx   = tx[SW-1] ? SW'(-tx) : SW'(tx);
  assign ny   = ty[SW-1] ? SW'(-ty) : SW'(ty);
  assign dm   = tw[SW-1] ? SW'(-tw) : SW'(tw);
  assign dtop = RW'(dm) << QB;

  always_comb begin
    prep_d          = '0;
    prep_d.zero_den = (tw == '0);
    prep_d.neg_x    = tx[SW-1] ^ tw[SW-1];
    prep_d.neg_y    = ty[SW-1] ^ tw[SW-1];
    prep_d.nz_x     = (tx != '0);
    prep_d.nz_y     = (ty != '0);
    prep_d.den      = dm;
    prep_d.rem_x    = RW'(nx) << FRAC_BITS;
    prep_d.rem_y    = RW'(ny) << FRAC_BITS;
    prep_d.ovf_x    = (RW'(nx) << FRAC_BITS) >= dtop;
    prep_d.ovf_y    = (RW'(ny) << FRAC_BITS) >= dtop;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (en) begin
      prep_v_q <= vx & vy & vw;
    end
  end

  // restoring divider chain, quotient bit QB-1 first
  logic          cv [QB+1];
  ppt_pkg::div_t cd [QB+1];

  assign cv[0] = prep_v_q;
  assign cd[0] = prep_q;

  for (genvar g = 0; g < QB; g++) begin : g_cell
    ppt_div_cell #(.BIT(QB - 1 - g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(cv[g]), .data_i(cd[g]),
      .valid_o(cv[g+1]), .data_o(cd[g+1])
    );
  end

  // saturation and sign
  ppt_pkg::div_t             fin;
  logic [QB-1:0]             lim_x, lim_y, mag_x, mag_y;
  logic                      sat_x, sat_y;
  logic [ppt_pkg::PT_W-1:0]  ox_d, oy_d, ox_q, oy_q;
  logic                      bad_d, bad_q, rv_q;
  localparam logic [QB-1:0]  POS_LIM = QB'((1 << (ppt_pkg::PT_W - 1)) - 1);
  localparam logic [QB-1:0]  NEG_LIM = QB'(1 << (ppt_pkg::PT_W - 1));

  assign fin   = cd[QB];
  assign lim_x = fin.neg_x ? NEG_LIM : POS_LIM;
  assign lim_y = fin.neg_y ? NEG_LIM : POS_LIM;
  assign sat_x = fin.ovf_x || (fin.q_x > lim_x);
  assign sat_y = fin.ovf_y || (fin.q_y > lim_y);

  always_comb begin
    if (fin.zero_den) begin
      mag_x = fin.nz_x ? lim_x : '0;
      mag_y = fin.nz_y ? lim_y : '0;
      bad_d = 1'b1;
    end else begin
      mag_x = sat_x ? lim_x : fin.q_x;
      mag_y = sat_y ? lim_y : fin.q_y;
      bad_d = sat_x | sat_y;
    end
    ox_d = fin.neg_x ? ppt_pkg::PT_W'(-mag_x) : ppt_pkg::PT_W'(mag_x);
    oy_d = fin.neg_y ? ppt_pkg::PT_W'(-mag_y) : ppt_pkg::PT_W'(mag_y);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      bad_q <= bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= cv[QB];
    end
  end

  assign result_o.valid      = rv_q;
  assign result_o.out_x      = $signed(ox_q);
  assign result_o.out_y      = $signed(oy_q);
  assign result_o.bad_divide = bad_q;

endmodule
